// ===== hw/rtl/msp_pkg.sv =====
// shared types and constants of the sequence header parser
// no dependencies; used by msp_front, msp_queue, msp_back and the top level
package msp_pkg;

    localparam int QUEUE_DEPTH = 4;

    // result kinds, carried on m_tuser
    localparam logic [2:0] KIND_INTRA    = 3'd0;
    localparam logic [2:0] KIND_NONINTRA = 3'd1;
    localparam logic [2:0] KIND_OK       = 3'd2;
    localparam logic [2:0] KIND_MARKER   = 3'd3;
    localparam logic [2:0] KIND_TRUNC    = 3'd4;

    localparam logic [5:0] COEF_LAST = 6'd63;

    localparam int OUT_DATA_W = 136;
    localparam int OUT_KIND_W = 3;

    // raw header fields as captured from the byte stream
    typedef struct packed {
        logic [11:0] width;
        logic [11:0] height;
        logic [3:0]  aspect_code;
        logic [3:0]  rate_code;
        logic [17:0] bitrate_code;
        logic [9:0]  vbv;
        logic [2:0]  flags;
    } hdr_fields_t;

    // one queue entry: the one or two results caused by one input beat
    typedef struct packed {
        logic [2:0]  kind0;
        logic        two;
        logic [2:0]  kind1;
        logic [5:0]  coef_index;
        logic [7:0]  coef_value;
        hdr_fields_t hdr;
    } cmd_t;

endpackage

// ===== hw/rtl/msp_front.sv =====
// front end: walks the header byte by byte and turns each beat that gives a result into a queue entry
// depends on msp_pkg
module msp_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  logic [7:0]     data_byte,
    input  logic           header_start,
    input  logic           buffer_end,
    output logic           push,
    output msp_pkg::cmd_t  cmd
);

    localparam logic [1:0] SEG_HDR   = 2'd0;
    localparam logic [1:0] SEG_INTRA = 2'd1;
    localparam logic [1:0] SEG_NONI  = 2'd2;

    logic                 active_reg, active_next;
    logic [1:0]           seg_reg, seg_next;
    logic [5:0]           cnt_reg, cnt_next;
    logic                 carry_reg, carry_next;
    msp_pkg::hdr_fields_t hdr_reg, hdr_next;

    logic                 eff_active;
    logic [1:0]           eff_seg;
    logic [5:0]           eff_cnt;
    logic                 has0, has1, done, sum_now;
    logic [2:0]           kind0, kind1;
    logic [7:0]           coef_value;

    always_comb
    begin
        eff_active  = header_start | active_reg;
        eff_seg     = header_start ? SEG_HDR : seg_reg;
        eff_cnt     = header_start ? 6'd0 : cnt_reg;
        seg_next    = eff_seg;
        cnt_next    = eff_cnt;
        carry_next  = carry_reg;
        hdr_next    = hdr_reg;
        has0        = 1'b0;
        has1        = 1'b0;
        kind0       = msp_pkg::KIND_INTRA;
        kind1       = msp_pkg::KIND_TRUNC;
        coef_value  = data_byte;
        done        = 1'b0;
        sum_now     = 1'b0;

        if (eff_active)
        begin
            case (eff_seg)
                SEG_HDR:
                begin
                    cnt_next = eff_cnt + 6'd1;
                    case (eff_cnt[2:0])
                        3'd0: hdr_next.width[11:4] = data_byte;
                        3'd1:
                        begin
                            hdr_next.width[3:0]   = data_byte[7:4];
                            hdr_next.height[11:8] = data_byte[3:0];
                        end
                        3'd2: hdr_next.height[7:0] = data_byte;
                        3'd3:
                        begin
                            hdr_next.aspect_code = data_byte[7:4];
                            hdr_next.rate_code   = data_byte[3:0];
                        end
                        3'd4: hdr_next.bitrate_code[17:10] = data_byte;
                        3'd5: hdr_next.bitrate_code[9:2]   = data_byte;
                        3'd6:
                        begin
                            hdr_next.bitrate_code[1:0] = data_byte[7:6];
                            hdr_next.vbv[9:5]          = data_byte[4:0];
                            // marker bit low ends the run at once
                            if (!data_byte[5])
                            begin
                                has0  = 1'b1;
                                kind0 = msp_pkg::KIND_MARKER;
                                done  = 1'b1;
                            end
                        end
                        3'd7:
                        begin
                            hdr_next.vbv[4:0] = data_byte[7:3];
                            hdr_next.flags    = {1'b0, data_byte[1], data_byte[2]};
                            cnt_next          = 6'd0;
                            if (data_byte[1])
                            begin
                                // intra matrix starts on the last bit of this byte
                                carry_next = data_byte[0];
                                seg_next   = SEG_INTRA;
                            end
                            else if (data_byte[0])
                            begin
                                hdr_next.flags[2] = 1'b1;
                                seg_next          = SEG_NONI;
                            end
                            else
                            begin
                                sum_now = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                SEG_INTRA:
                begin
                    // intra coefficients straddle byte boundaries by one bit
                    has0       = 1'b1;
                    kind0      = msp_pkg::KIND_INTRA;
                    coef_value = {carry_reg, data_byte[7:1]};
                    carry_next = data_byte[0];
                    cnt_next   = eff_cnt + 6'd1;
                    if (eff_cnt == msp_pkg::COEF_LAST)
                    begin
                        if (data_byte[0])
                        begin
                            hdr_next.flags[2] = 1'b1;
                            seg_next          = SEG_NONI;
                            cnt_next          = 6'd0;
                        end
                        else
                        begin
                            sum_now = 1'b1;
                        end
                    end
                end
                SEG_NONI:
                begin
                    has0     = 1'b1;
                    kind0    = msp_pkg::KIND_NONINTRA;
                    cnt_next = eff_cnt + 6'd1;
                    if (eff_cnt == msp_pkg::COEF_LAST)
                    begin
                        sum_now = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        // header summary goes behind any coefficient of the same beat
        if (sum_now)
        begin
            done = 1'b1;
            if (has0)
            begin
                has1  = 1'b1;
                kind1 = msp_pkg::KIND_OK;
            end
            else
            begin
                has0  = 1'b1;
                kind0 = msp_pkg::KIND_OK;
            end
        end

        active_next = eff_active & ~done;

        if (buffer_end && active_next)
        begin
            active_next = 1'b0;
            if (has0)
            begin
                has1  = 1'b1;
                kind1 = msp_pkg::KIND_TRUNC;
            end
            else
            begin
                has0  = 1'b1;
                kind0 = msp_pkg::KIND_TRUNC;
            end
        end
    end

    assign push           = accept & has0;
    assign cmd.kind0      = kind0;
    assign cmd.two        = has1;
    assign cmd.kind1      = kind1;
    assign cmd.coef_index = eff_cnt;
    assign cmd.coef_value = coef_value;
    assign cmd.hdr        = hdr_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            seg_reg    <= SEG_HDR;
            cnt_reg    <= 6'd0;
        end
        else if (accept)
        begin
            active_reg <= active_next;
            seg_reg    <= seg_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            carry_reg <= carry_next;
            hdr_reg   <= hdr_next;
        end
    end

endmodule

// ===== hw/rtl/msp_queue.sv =====
// short command queue between front end and back end
// depends on msp_pkg
module msp_queue
#(
    parameter int DEPTH = msp_pkg::QUEUE_DEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  msp_pkg::cmd_t  push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output msp_pkg::cmd_t  head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    msp_pkg::cmd_t     mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push, do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign head    = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== hw/rtl/msp_back.sv =====
// back end: expands queue entries into result beats, table lookups for the summary
// depends on msp_pkg
module msp_back
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            empty,
    input  msp_pkg::cmd_t                   head,
    output logic                            pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [msp_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic [msp_pkg::OUT_KIND_W-1:0]  m_tuser
);

    function automatic logic [27:0] aspect_lookup(input logic [3:0] code);
        logic [27:0] r;
        case (code)
            4'd1:    r = {14'd1,     14'd1};
            4'd2:    r = {14'd10000, 14'd6735};
            4'd3:    r = {14'd64,    14'd45};
            4'd4:    r = {14'd10000, 14'd7615};
            4'd5:    r = {14'd10000, 14'd8055};
            4'd6:    r = {14'd32,    14'd27};
            4'd7:    r = {14'd10000, 14'd8935};
            4'd8:    r = {14'd10000, 14'd9375};
            4'd9:    r = {14'd10000, 14'd9815};
            4'd10:   r = {14'd10000, 14'd10255};
            4'd11:   r = {14'd10000, 14'd10695};
            4'd12:   r = {14'd8,     14'd9};
            4'd13:   r = {14'd10000, 14'd11575};
            4'd14:   r = {14'd10000, 14'd12015};
            default: r = 28'd0;
        endcase
        return r;
    endfunction

    function automatic logic [25:0] rate_lookup(input logic [3:0] code);
        logic [25:0] r;
        case (code)
            4'd1:    r = {16'd24000, 10'd1001};
            4'd2:    r = {16'd24,    10'd1};
            4'd3:    r = {16'd25,    10'd1};
            4'd4:    r = {16'd30000, 10'd1001};
            4'd5:    r = {16'd30,    10'd1};
            4'd6:    r = {16'd50,    10'd1};
            4'd7:    r = {16'd60000, 10'd1001};
            4'd8:    r = {16'd60,    10'd1};
            4'd9:    r = {16'd30,    10'd1};
            default: r = {16'd30000, 10'd1001};
        endcase
        return r;
    endfunction

    logic                              valid_reg;
    logic                              sel_reg, sel_next;
    logic [msp_pkg::OUT_DATA_W-1:0]    data_reg, data_next;
    logic [msp_pkg::OUT_KIND_W-1:0]    kind_reg, kind_next;
    logic                              load;
    logic [27:0]                       aspect;
    logic [25:0]                       rate;
    logic [26:0]                       bps_mul, bps;

    assign load     = ~empty & (~valid_reg | m_tready);
    assign pop      = load & (~head.two | sel_reg);
    assign sel_next = head.two & ~sel_reg;
    assign aspect   = aspect_lookup(head.hdr.aspect_code);
    assign rate     = rate_lookup(head.hdr.rate_code);
    assign bps_mul  = {9'd0, head.hdr.bitrate_code} * 27'd400;
    assign bps      = (head.hdr.bitrate_code == 18'h3ffff) ? 27'd0 : bps_mul;

    always_comb
    begin
        kind_next = sel_reg ? head.kind1 : head.kind0;
        data_next = '0;
        case (kind_next)
            msp_pkg::KIND_INTRA, msp_pkg::KIND_NONINTRA:
            begin
                data_next[5:0]  = head.coef_index;
                data_next[13:6] = head.coef_value;
            end
            msp_pkg::KIND_OK:
            begin
                data_next[25:14]   = head.hdr.width;
                data_next[37:26]   = head.hdr.height;
                data_next[51:38]   = aspect[27:14];
                data_next[65:52]   = aspect[13:0];
                data_next[81:66]   = rate[25:10];
                data_next[91:82]   = rate[9:0];
                data_next[118:92]  = bps;
                data_next[128:119] = head.hdr.vbv;
                data_next[131:129] = head.hdr.flags;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                sel_reg   <= sel_next;
            end
            else if (m_tready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
            kind_reg <= kind_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = kind_reg;

endmodule

// ===== hw/rtl/mpeg_sequence_header_parser.sv =====
// sequence header parser: one payload byte per beat, up to two result beats per byte
// a result beat is held in a queue entry and then in the back-end output register
// throughput: one byte per cycle while the queue is not full; a byte that gives two results
// (a coefficient followed by summary or truncation) is sent by the back end as two output beats
// reset: rst_n asynchronous active low, clears parse state, queue and output valid
// depends on msp_pkg, msp_front, msp_queue, msp_back
module mpeg_sequence_header_parser
#(
    parameter int QUEUE_DEPTH = msp_pkg::QUEUE_DEPTH
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // input beats
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,  // [7:0] data_byte
    input  logic                            s_tuser,  // [0] header_start
    input  logic                            s_tlast,  // buffer_end
    // result beats
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [5:0] coef_index, [13:6] coef_value, [25:14] pic_width, [37:26] pic_height,
    // [51:38] aspect_num, [65:52] aspect_den, [81:66] rate_num, [91:82] rate_den,
    // [118:92] bits_per_second, [128:119] vbv_size, [131:129] header_flags, rest zero
    output logic [msp_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic [msp_pkg::OUT_KIND_W-1:0]  m_tuser   // [2:0] out_kind
);

    logic           accept;
    logic           q_push, q_full, q_pop, q_empty;
    msp_pkg::cmd_t  q_in, q_head;

    // the front end never waits on the back end directly, only on queue space
    assign s_tready = ~q_full;
    assign accept   = s_tvalid & s_tready;

    // front: bit-field walk of the header, one byte per beat
    msp_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .data_byte    (s_tdata),
        .header_start (s_tuser),
        .buffer_end   (s_tlast),
        .push         (q_push),
        .cmd          (q_in)
    );

    // entries carry their own copy of the header fields, so a restart cannot
    // disturb a summary still waiting in the queue
    msp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_in),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    // back: summary tables and bitrate scaling, output register
    msp_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (q_empty),
        .head     (q_head),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
